// ===== rtl/core/hpe_pkg.sv =====
// shared types and codes for the hermite path evaluator
package hpe_pkg;

  // one control point: position and tangent
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } point_t;

  // one result word
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               moved;
  } res_t;

  // item kinds passed from front to back
  localparam logic [2:0] KIND_NOP    = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_STILL  = 3'd2;
  localparam logic [2:0] KIND_SINGLE = 3'd3;
  localparam logic [2:0] KIND_BLEND  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_SPEED      = 2'd0;
  localparam logic [1:0] REG_BIAS       = 2'd1;
  localparam logic [1:0] REG_NUM_POINTS = 2'd2;

  // input op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

endpackage

// ===== rtl/core/hpe_ram.sv =====
// generic single write port ram with registered read
module hpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/hpe_fifo.sv =====
// small register fifo, used as the queue between the block's parts and as the result queue
module hpe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_pop;

  assign do_pop = pop && (count_r != '0);
  assign empty  = (count_r == '0);
  assign dout   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_r + CW'(push) - CW'(do_pop);
    end
  end

endmodule

// ===== rtl/core/hpe_front.sv =====
// front part: config registers, lifetime scaling and item classification
module hpe_front import hpe_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16,
  parameter int AW         = 6,
  parameter int MQD        = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_wdata,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_op,
  input  logic [5:0]            in_point_index,
  input  point_t                in_pt,
  input  logic signed [31:0]    in_lifetime,
  input  logic                  mq_pop,
  output logic                  mq_push,
  output logic [2:0]            mq_kind,
  output logic [AW-1:0]         mq_addr,
  output logic signed [FRAC_BITS:0] mq_frac,
  output point_t                mq_pt
);

  localparam int TW = 65 - FRAC_BITS;
  localparam int SW = TW - FRAC_BITS;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = $clog2(MQD + 1);
  localparam logic signed [TW-1:0] NEG_ONE = -(TW'(1) << FRAC_BITS);

  logic signed [31:0] speed_r;
  logic signed [31:0] bias_r;
  logic [6:0]         num_points_r;
  logic [CW-1:0]      pend_r;
  logic               s1_vld_r;
  logic               s1_op_r;
  logic [5:0]         s1_idx_r;
  point_t             s1_pt_r;
  logic signed [63:0] s1_prod_r;
  logic               accept;
  logic [NW-1:0]      n_w;
  logic signed [TW-1:0] t_w;
  logic [SW-1:0]      seg_w;

  assign accept  = in_push && !in_full;
  assign in_full = (pend_r == CW'(MQD));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r      <= 32'(1) << FRAC_BITS;
      bias_r       <= '0;
      num_points_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SPEED:      speed_r      <= cfg_wdata;
        REG_BIAS:       bias_r       <= cfg_wdata;
        REG_NUM_POINTS: num_points_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // words accepted and not yet handed to the back part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      pend_r   <= pend_r + CW'(accept) - CW'(mq_pop);
      s1_vld_r <= accept;
    end
  end

  // capture stage with lifetime times speed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= in_op;
      s1_idx_r  <= in_point_index;
      s1_pt_r   <= in_pt;
      s1_prod_r <= in_lifetime * speed_r;
    end
  end

  // path position and segment
  assign n_w   = (32'(num_points_r) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(num_points_r);
  assign t_w   = TW'(s1_prod_r >>> FRAC_BITS) + TW'(bias_r);
  assign seg_w = t_w[TW-1:FRAC_BITS];

  // classify the word
  always_comb begin
    mq_kind = KIND_STILL;
    mq_addr = '0;
    mq_frac = '0;
    mq_pt   = s1_pt_r;
    if (s1_op_r == OP_WRITE) begin
      mq_kind = (32'(s1_idx_r) < 32'(MAX_POINTS)) ? KIND_WRITE : KIND_NOP;
      mq_addr = AW'(s1_idx_r);
    end else if (n_w == '0) begin
      mq_kind = KIND_STILL;
    end else if (n_w == NW'(1)) begin
      mq_kind = KIND_SINGLE;
    end else if (t_w <= NEG_ONE) begin
      mq_kind = KIND_STILL;
    end else if (t_w < 0) begin
      mq_kind = KIND_BLEND;
      mq_frac = t_w[FRAC_BITS:0];
    end else if (seg_w > SW'(n_w) - SW'(2)) begin
      mq_kind = KIND_STILL;
    end else begin
      mq_kind = KIND_BLEND;
      mq_addr = seg_w[AW-1:0];
      mq_frac = {1'b0, t_w[FRAC_BITS-1:0]};
    end
  end

  assign mq_push = s1_vld_r;

endmodule

// ===== rtl/core/hpe_back.sv =====
// back part: point table, hermite weights and blend pipeline
module hpe_back import hpe_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16,
  parameter int AW         = 6,
  parameter int OFD        = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      mq_empty,
  output logic                      mq_pop,
  input  logic [2:0]                mq_kind,
  input  logic [AW-1:0]             mq_addr,
  input  logic signed [FRAC_BITS:0] mq_frac,
  input  point_t                    mq_pt,
  input  logic                      out_taken,
  output logic                      res_push,
  output res_t                      res
);

  localparam int FB = FRAC_BITS + 1;
  localparam int HW = FRAC_BITS + 4;
  localparam int PW = 32 + HW;
  localparam int SUMW = PW + 2;
  localparam int CW = $clog2(OFD + 1);
  localparam logic signed [HW-1:0] ONE_H = HW'(1) << FRAC_BITS;

  logic [CW-1:0] pend_r;
  logic          is_eval;
  point_t        ram_a;
  point_t        ram_b;
  point_t        pa_m;
  point_t        pb_m;

  logic                 s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [2:0]           s1_kind_r, s2_kind_r;
  logic                 s3_moved_r, s4_moved_r;
  logic signed [FB-1:0] s1_f_r, s2_f_r;
  logic signed [FB-1:0] s1_t2_r, s2_t2_r;
  logic signed [FB-1:0] s2_t3_r;
  point_t               s2_pa_r, s2_pb_r, s3_pa_r, s3_pb_r;
  logic signed [HW-1:0] s3_h00_r, s3_h10_r, s3_h11_r, s3_h01_r;
  logic signed [PW-1:0] s4_prod_r [12];

  logic signed [2*FB-1:0] ff_w;
  logic signed [2*FB-1:0] tf_w;
  logic signed [HW-1:0]   fe, t2e, t3e;
  logic signed [HW-1:0]   h00_nxt, h10_nxt, h11_nxt, h01_nxt;
  logic signed [31:0]     pos_w [3];

  // issue from the queue only with room left in the result queue
  assign mq_pop  = !mq_empty && (pend_r < CW'(OFD));
  assign is_eval = mq_kind inside {KIND_STILL, KIND_SINGLE, KIND_BLEND};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + CW'(mq_pop && is_eval) - CW'(out_taken);
    end
  end

  // point table, one copy per read address
  hpe_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_ram_a (
    .clk     (clk),
    .wr_en   (mq_pop && (mq_kind == KIND_WRITE)),
    .wr_addr (mq_addr),
    .wr_data (mq_pt),
    .rd_addr (mq_addr),
    .rd_data (ram_a)
  );

  hpe_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_ram_b (
    .clk     (clk),
    .wr_en   (mq_pop && (mq_kind == KIND_WRITE)),
    .wr_addr (mq_addr),
    .wr_data (mq_pt),
    .rd_addr (mq_addr + AW'(1)),
    .rd_data (ram_b)
  );

  // valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= mq_pop && is_eval;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // stage 1: fraction squared
  assign ff_w = mq_frac * mq_frac;

  always_ff @(posedge clk) begin
    s1_kind_r <= mq_kind;
    s1_f_r    <= mq_frac;
    s1_t2_r   <= FB'(ff_w >>> FRAC_BITS);
  end

  // stage 2: fraction cubed, table words masked by kind
  assign tf_w = s1_t2_r * s1_f_r;

  always_comb begin
    pa_m = ram_a;
    pb_m = ram_b;
    if (s1_kind_r == KIND_STILL) begin
      pa_m = '0;
    end
    if (s1_kind_r != KIND_BLEND) begin
      pa_m.tx = '0;
      pa_m.ty = '0;
      pa_m.tz = '0;
      pb_m    = '0;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind_r <= s1_kind_r;
    s2_f_r    <= s1_f_r;
    s2_t2_r   <= s1_t2_r;
    s2_t3_r   <= FB'(tf_w >>> FRAC_BITS);
    s2_pa_r   <= pa_m;
    s2_pb_r   <= pb_m;
  end

  // stage 3: basis weights
  assign fe  = HW'(s2_f_r);
  assign t2e = HW'(s2_t2_r);
  assign t3e = HW'(s2_t3_r);
  assign h00_nxt = (t3e <<< 1) - (t2e + (t2e <<< 1)) + ONE_H;
  assign h10_nxt = t3e - (t2e <<< 1) + fe;
  assign h11_nxt = t3e - t2e;
  assign h01_nxt = (t2e + (t2e <<< 1)) - (t3e <<< 1);

  always_ff @(posedge clk) begin
    s3_moved_r <= (s2_kind_r != KIND_STILL);
    s3_h00_r   <= h00_nxt;
    s3_h10_r   <= h10_nxt;
    s3_h11_r   <= h11_nxt;
    s3_h01_r   <= h01_nxt;
    s3_pa_r    <= s2_pa_r;
    s3_pb_r    <= s2_pb_r;
  end

  // stage 4: twelve products
  always_ff @(posedge clk) begin
    s4_moved_r   <= s3_moved_r;
    s4_prod_r[0] <= s3_pa_r.vx * s3_h00_r;
    s4_prod_r[1] <= s3_pa_r.tx * s3_h10_r;
    s4_prod_r[2] <= s3_pb_r.tx * s3_h11_r;
    s4_prod_r[3] <= s3_pb_r.vx * s3_h01_r;
    s4_prod_r[4] <= s3_pa_r.vy * s3_h00_r;
    s4_prod_r[5] <= s3_pa_r.ty * s3_h10_r;
    s4_prod_r[6] <= s3_pb_r.ty * s3_h11_r;
    s4_prod_r[7] <= s3_pb_r.vy * s3_h01_r;
    s4_prod_r[8] <= s3_pa_r.vz * s3_h00_r;
    s4_prod_r[9] <= s3_pa_r.tz * s3_h10_r;
    s4_prod_r[10] <= s3_pb_r.tz * s3_h11_r;
    s4_prod_r[11] <= s3_pb_r.vz * s3_h01_r;
  end

  // sum, scale back and saturate each component
  always_comb begin
    logic signed [SUMW-1:0] sum;
    logic signed [SUMW-1:0] sh;
    for (int k = 0; k < 3; k++) begin
      sum = SUMW'(s4_prod_r[4*k]) + SUMW'(s4_prod_r[4*k+1])
          + SUMW'(s4_prod_r[4*k+2]) + SUMW'(s4_prod_r[4*k+3]);
      sh  = sum >>> FRAC_BITS;
      if ((&sh[SUMW-1:31]) || !(|sh[SUMW-1:31])) begin
        pos_w[k] = sh[31:0];
      end else if (sh[SUMW-1]) begin
        pos_w[k] = {1'b1, 31'd0};
      end else begin
        pos_w[k] = {1'b0, {31{1'b1}}};
      end
    end
  end

  assign res_push  = s4_vld_r;
  assign res.px    = pos_w[0];
  assign res.py    = pos_w[1];
  assign res.pz    = pos_w[2];
  assign res.moved = s4_moved_r;

endmodule

// ===== rtl/core/hermite_path_evaluator_unit.sv =====
// top level of the hermite path evaluator
//
// Input queue side: drive the word on in_* and raise in_push; it is taken at an
// edge with in_push high and in_full low. op 0 loads one control point into the
// table, op 1 evaluates the path at in_lifetime and gives exactly one result.
// Result queue side: while out_empty is low the oldest result is on out_*;
// raise out_pop to take it. Results come out in the order of the evaluations.
// Config: cfg_wr_en with cfg_index and cfg_wdata writes speed, bias or the
// point count; write only while no evaluation is under way.
// Throughput is one word per clock on both sides while in_full stays low and out_pop
// stays high. An evaluation passes the lifetime multiply register, then the
// classification into the front queue, then the back pipeline stages (table read
// with fraction squared, fraction cubed, weights, products with the sum going into
// the result queue) before its result shows on out_*.
// Table writes travel the same queue, so they stay in order with evaluations.
// When out_pop stays low the result queue fills, the back part stops reading
// the front queue, and in_full rises once the front queue is full.
// Reset clears both queues and restores speed 1.0, bias 0 and zero points;
// table contents are unknown until written.
module hermite_path_evaluator_unit import hpe_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_op,
  input  logic [5:0]         in_point_index,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic signed [31:0] in_value_z,
  input  logic signed [31:0] in_tangent_x,
  input  logic signed [31:0] in_tangent_y,
  input  logic signed [31:0] in_tangent_z,
  input  logic signed [31:0] in_lifetime,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic               out_moved
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int MQD = 8;
  localparam int OFD = 8;
  localparam int MW  = 3 + AW + FRAC_BITS + 1 + $bits(point_t);

  point_t                    in_pt;
  logic                      f_push, b_pop, mq_empty;
  logic [2:0]                f_kind, b_kind;
  logic [AW-1:0]             f_addr, b_addr;
  logic signed [FRAC_BITS:0] f_frac, b_frac;
  point_t                    f_pt, b_pt;
  logic [MW-1:0]             mq_dout;
  logic                      res_push;
  res_t                      res, res_out;
  logic                      out_taken;

  assign in_pt = '{vx: in_value_x, vy: in_value_y, vz: in_value_z,
                   tx: in_tangent_x, ty: in_tangent_y, tz: in_tangent_z};

  // front part
  hpe_front #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS),
    .AW         (AW),
    .MQD        (MQD)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_point_index (in_point_index),
    .in_pt          (in_pt),
    .in_lifetime    (in_lifetime),
    .mq_pop         (b_pop),
    .mq_push        (f_push),
    .mq_kind        (f_kind),
    .mq_addr        (f_addr),
    .mq_frac        (f_frac),
    .mq_pt          (f_pt)
  );

  // queue between front and back
  hpe_fifo #(.WIDTH(MW), .DEPTH(MQD)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   ({f_kind, f_addr, f_frac, f_pt}),
    .pop   (b_pop),
    .dout  (mq_dout),
    .empty (mq_empty)
  );

  assign {b_kind, b_addr, b_frac, b_pt} = mq_dout;

  // back part
  hpe_back #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS),
    .AW         (AW),
    .OFD        (OFD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mq_empty  (mq_empty),
    .mq_pop    (b_pop),
    .mq_kind   (b_kind),
    .mq_addr   (b_addr),
    .mq_frac   (b_frac),
    .mq_pt     (b_pt),
    .out_taken (out_taken),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue
  assign out_taken = out_pop && !out_empty;

  hpe_fifo #(.WIDTH($bits(res_t)), .DEPTH(OFD)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign out_pos_x = res_out.px;
  assign out_pos_y = res_out.py;
  assign out_pos_z = res_out.pz;
  assign out_moved = res_out.moved;

endmodule

// ===== rtl/core/hpe_checker.sv =====
// port level checks for the hermite path evaluator, bound to the top level
module hpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               in_op,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_pos_x,
  input logic signed [31:0] out_pos_y,
  input logic signed [31:0] out_pos_z,
  input logic               out_moved
);

  logic [15:0] owed_r;

  // evaluations taken minus results taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0;
    end else begin
      owed_r <= owed_r + 16'(in_push && !in_full && in_op)
                       - 16'(out_pop && !out_empty);
    end
  end

  // both queues come out of reset empty
  a_reset_clean: assert property (@(posedge clk)
    (!$past(rst_n) && rst_n) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a result only shows up for an evaluation still owed
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (owed_r != 16'd0))
    else $error("result without a pending evaluation");

  // an unmoved result carries zero positions
  a_still_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_moved) |->
      (out_pos_x == 32'sd0 && out_pos_y == 32'sd0 && out_pos_z == 32'sd0))
    else $error("unmoved result with nonzero position");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_pos_x) && $stable(out_pos_y)
       && $stable(out_pos_z) && $stable(out_moved)))
    else $error("waiting result changed");

endmodule

bind hermite_path_evaluator_unit hpe_checker u_hpe_checker (.*);

// ===== verif/hermite_path_evaluator_unit_tb.sv =====
// testbench for the hermite path evaluator: directed table, then random phases
`timescale 1ns / 1ps

module hermite_path_evaluator_unit_tb;
  import hpe_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam longint ONE_Q = 64'sd65536;

  // one input word
  typedef struct {
    logic        op;
    logic [5:0]  idx;
    logic [31:0] vx, vy, vz, tx, ty, tz;
    logic [31:0] life;
  } word_t;

  // one row of the directed table
  typedef struct {
    word_t w;
    bit    typed;
    res_t  res;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_op = 1'b0;
  logic [5:0]         in_point_index = '0;
  logic signed [31:0] in_value_x = '0, in_value_y = '0, in_value_z = '0;
  logic signed [31:0] in_tangent_x = '0, in_tangent_y = '0, in_tangent_z = '0;
  logic signed [31:0] in_lifetime = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic               out_moved;

  hermite_path_evaluator_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the block's state
  logic signed [31:0] tbl_val [TBL_DEPTH][3];
  logic signed [31:0] tbl_tan [TBL_DEPTH][3];
  logic signed [31:0] cfg_speed = 32'sd65536;
  logic signed [31:0] cfg_bias = '0;
  logic [6:0]         cfg_count = '0;

  res_t pos_expected[$];
  int   n_err = 0;
  int   n_res = 0;
  int   n_words = 0;
  bit   no_gaps = 1'b0;
  int   pop_wait = 0;

  function automatic logic signed [31:0] sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // hermite blend of the path at one lifetime
  function automatic res_t path_eval(logic signed [31:0] life);
    res_t r;
    longint n, t, f, t2, t3, h00, h10, h11, h01, seg, acc;
    r = '0;
    n = (cfg_count > 7'd64) ? 64 : cfg_count;
    if (n == 0) return r;
    if (n == 1) begin
      r.px = tbl_val[0][0];
      r.py = tbl_val[0][1];
      r.pz = tbl_val[0][2];
      r.moved = 1'b1;
      return r;
    end
    t = ((longint'(life) * longint'(cfg_speed)) >>> 16) + longint'(cfg_bias);
    if (t <= -ONE_Q) return r;
    if (t < 0) begin
      seg = 0;
      f = t;
    end else begin
      seg = t >>> 16;
      f = t & (ONE_Q - 1);
    end
    if (seg > n - 2) return r;
    t2 = (f * f) >>> 16;
    t3 = (t2 * f) >>> 16;
    h00 = 2 * t3 - 3 * t2 + ONE_Q;
    h10 = t3 - 2 * t2 + f;
    h11 = t3 - t2;
    h01 = -2 * t3 + 3 * t2;
    for (int k = 0; k < 3; k++) begin
      acc = longint'(tbl_val[seg][k]) * h00 + longint'(tbl_tan[seg][k]) * h10
          + longint'(tbl_tan[seg + 1][k]) * h11 + longint'(tbl_val[seg + 1][k]) * h01;
      if (k == 0) r.px = sat32(acc >>> 16);
      else if (k == 1) r.py = sat32(acc >>> 16);
      else r.pz = sat32(acc >>> 16);
    end
    r.moved = 1'b1;
    return r;
  endfunction

  // push one word; called at a rising edge, returns at the accepting edge
  task automatic send_word(word_t w, bit typed, res_t res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_op <= w.op;
    in_point_index <= w.idx;
    in_value_x <= w.vx;
    in_value_y <= w.vy;
    in_value_z <= w.vz;
    in_tangent_x <= w.tx;
    in_tangent_y <= w.ty;
    in_tangent_z <= w.tz;
    in_lifetime <= w.life;
    do @(posedge clk); while (in_full);
    n_words++;
    if (w.op == OP_WRITE) begin
      tbl_val[w.idx][0] = w.vx;
      tbl_val[w.idx][1] = w.vy;
      tbl_val[w.idx][2] = w.vz;
      tbl_tan[w.idx][0] = w.tx;
      tbl_tan[w.idx][1] = w.ty;
      tbl_tan[w.idx][2] = w.tz;
    end else begin
      pos_expected.push_back(typed ? res : path_eval(w.life));
    end
  endtask

  // all three registers, one per cycle, only while idle
  task automatic write_regs(logic [31:0] spd, logic [31:0] bs, logic [31:0] cnt);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SPEED;
    cfg_wdata <= spd;
    @(posedge clk);
    cfg_index <= REG_BIAS;
    cfg_wdata <= bs;
    @(posedge clk);
    cfg_index <= REG_NUM_POINTS;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_speed = spd;
    cfg_bias = bs;
    cfg_count = cnt[6:0];
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pos_expected.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t rnd_write();
    word_t w;
    w.op = OP_WRITE;
    w.idx = $urandom_range(0, TBL_DEPTH - 1);
    w.vx = rnd_word();
    w.vy = rnd_word();
    w.vz = rnd_word();
    w.tx = rnd_word();
    w.ty = rnd_word();
    w.tz = rnd_word();
    w.life = $urandom;
    return w;
  endfunction

  // lifetime aimed at a point of the path, or anywhere
  function automatic logic [31:0] rnd_life();
    longint n, tgt, lt;
    n = (cfg_count > 7'd64) ? 64 : cfg_count;
    if ($urandom_range(0, 3) == 0 || cfg_speed == 0) return rnd_word();
    tgt = longint'($urandom_range(0, (n + 3) * 65536)) - 2 * ONE_Q;
    lt = ((tgt - longint'(cfg_bias)) * ONE_Q) / longint'(cfg_speed);
    if (lt > 64'sd2147483647 || lt < -64'sd2147483648) return $urandom;
    return lt[31:0];
  endfunction

  // result side: random stalls, compare each word with the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_pop && !out_empty) begin
      n_res++;
      if (pos_expected.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result word %0d", n_res);
      end else begin
        e = pos_expected.pop_front();
        if (e.px !== out_pos_x || e.py !== out_pos_y || e.pz !== out_pos_z ||
            e.moved !== out_moved) begin
          n_err++;
          if (n_err <= 10)
            $display("result %0d: expected %h %h %h moved %b, got %h %h %h moved %b",
                     n_res, e.px, e.py, e.pz, e.moved,
                     out_pos_x, out_pos_y, out_pos_z, out_moved);
        end
      end
      pop_wait = no_gaps ? 0 : $urandom_range(0, 7);
      if (pop_wait != 0) out_pop <= 1'b0;
    end else if (rst_n && !out_pop) begin
      if (pop_wait == 0) out_pop <= 1'b1;
      else pop_wait--;
    end
  end

  initial begin
    #2_000_000;
    $display("hermite_path_evaluator_unit_tb: done, errors");
    $finish;
  end

  initial begin
    row_t dir[12];
    word_t w;
    res_t none;
    logic [31:0] ph_speed[14];
    logic [31:0] ph_bias[14];
    logic [31:0] ph_cnt[14];
    int n_ph_items;

    none = '0;
    // directed table: with zero points every evaluation stays unmoved
    foreach (dir[i]) begin
      dir[i].w = '{OP_EVAL, 6'd0, 0, 0, 0, 0, 0, 0, 0};
      dir[i].typed = 1'b1;
      dir[i].res = none;
    end
    dir[0].w.life = 32'h0;
    dir[1].w.life = 32'h7fffffff;
    dir[2].w.life = 32'h80000000;
    dir[3].w = '{OP_WRITE, 6'd0, 32'h7fffffff, 32'h80000000, 0,
                 32'h80000000, 32'h7fffffff, 32'hffffffff, 0};
    dir[3].typed = 1'b0;
    dir[4].w = '{OP_WRITE, 6'd63, 32'h80000000, 32'h7fffffff, 32'hffffffff,
                 32'h7fffffff, 0, 32'h80000000, 32'hffffffff};
    dir[4].typed = 1'b0;
    dir[5].w.life = 32'hffffffff;
    dir[6].w.life = 32'h00010000;
    dir[7].w = '{OP_WRITE, 6'd1, 32'h00010000, 32'hffff0000, 32'h00008000,
                 32'h00020000, 32'h0, 32'hfffe0000, 0};
    dir[7].typed = 1'b0;
    dir[8].w.life = 32'hffff8000;
    dir[9].w = '{OP_WRITE, 6'd42, 32'h55555555, 32'haaaaaaaa, 32'h12345678,
                 32'hedcba987, 32'h0f0f0f0f, 32'hf0f0f0f0, 32'haaaaaaaa};
    dir[9].typed = 1'b0;
    dir[10].w.life = 32'h55555555;
    dir[11].w.life = 32'haaaaaaaa;

    // settings per phase: extremes of speed, bias and point count among them
    ph_speed = '{32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000,
                 32'h00008000, 32'h7fffffff, 32'h80000000, 32'hffff0000, 32'h0,
                 32'h00010000, 32'h00030000, $urandom, $urandom};
    ph_bias = '{32'h0, 32'h0, 32'h0, 32'hffff8000, 32'h0,
                32'h00004000, 32'h0, 32'h0, 32'h00100000, 32'h00018000,
                32'h7fffffff, 32'h80000000, $urandom, $urandom};
    ph_cnt = '{32'd1, 32'd2, 32'd64, 32'd5, 32'd127,
               32'd10, 32'd64, 32'd64, 32'd20, 32'd3,
               32'd64, 32'd64, 32'hffffff80 | $urandom_range(0, 127), $urandom_range(0, 70)};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir[i]) send_word(dir[i].w, dir[i].typed, dir[i].res);

    // fill the whole table so that no evaluation reads an unwritten entry
    for (int i = 0; i < TBL_DEPTH; i++) begin
      w = rnd_write();
      w.idx = i;
      send_word(w, 1'b0, none);
    end
    drain();

    // random phases: mostly aimed evaluations, table writes mixed in
    foreach (ph_speed[p]) begin
      write_regs(ph_speed[p], ph_bias[p], ph_cnt[p]);
      n_ph_items = 135;
      for (int i = 0; i < n_ph_items; i++) begin
        if (i % 45 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) < 3) begin
          w = rnd_write();
        end else begin
          w = rnd_write();
          w.op = OP_EVAL;
          w.life = rnd_life();
        end
        send_word(w, 1'b0, none);
      end
      drain();
    end

    $display("words sent %0d, results checked %0d over %0d register settings",
             n_words, n_res, $size(ph_speed) + 1);
    if (n_err == 0) begin
      $display("hermite_path_evaluator_unit_tb: done, clean");
    end else begin
      $display("mismatches: %0d", n_err);
      $display("hermite_path_evaluator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
